// File: rtl/itd_pkg.sv
// Package for the signed decimal field formatter.
// Holds widths, ASCII codes and the command/status structs shared by the
// controller and the datapath. No dependencies.
`default_nettype none

package itd_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned WidthW        = 6;
  localparam int unsigned CharW         = 6;
  localparam int unsigned MaxFieldWidth = 63;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned BcdW          = 4 * NumDigits;
  localparam int unsigned BitCntW       = $clog2(ValueW);
  localparam int unsigned LenW          = 4;

  localparam logic [CharW-1:0] ChZero  = CharW'(48);
  localparam logic [CharW-1:0] ChMinus = CharW'(45);
  localparam logic [CharW-1:0] ChSpace = CharW'(32);

  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic emit;
  } itd_cmd_t;

  typedef struct packed {
    logic last_char;
  } itd_sts_t;

endpackage

`default_nettype wire

// File: rtl/itd_in_if.sv
// Input channel of the decimal formatter: valid/ready plus the field request.
// Depends on itd_pkg.
`default_nettype none

interface itd_in_if;
  import itd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic        [WidthW-1:0] field_width;
  logic                     left_adjust;
  logic                     zero_pad;

  modport source (output valid, output value, output field_width,
                  output left_adjust, output zero_pad, input ready);
  modport sink   (input valid, input value, input field_width,
                  input left_adjust, input zero_pad, output ready);
endinterface

`default_nettype wire

// File: rtl/itd_out_if.sv
// Output channel of the decimal formatter: valid/ready plus one character.
// Depends on itd_pkg.
`default_nettype none

interface itd_out_if;
  import itd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/itd_ctrl.sv
// Controller of the decimal formatter: sequences capture, binary-to-BCD
// conversion, sizing and character emission. Depends on itd_pkg.
`default_nettype none

module itd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire itd_pkg::itd_sts_t sts_i,
  output itd_pkg::itd_cmd_t      cmd_o
);
  import itd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSize = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               emit;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign emit        = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.load  = in_valid_i && in_ready_o;
    cmd_o.shift = (state_q == StConv);
    cmd_o.size  = (state_q == StSize);
    cmd_o.emit  = emit;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StConv;
          cnt_d   = BitCntW'(ValueW - 1);
        end
      end
      StConv: begin
        cnt_d = cnt_q - BitCntW'(1);
        if (cnt_q == '0) begin
          state_d = StSize;
        end
      end
      StSize: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (emit && sts_i.last_char) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/itd_datapath.sv
// Datapath of the decimal formatter: magnitude, shift-add-3 BCD converter,
// field sizing, position counter and output character register.
// Depends on itd_pkg.
`default_nettype none

module itd_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire itd_pkg::itd_cmd_t        cmd_i,
  output itd_pkg::itd_sts_t             sts_o,
  input  wire logic [itd_pkg::ValueW-1:0] value_i,
  input  wire logic [itd_pkg::WidthW-1:0] field_width_i,
  input  wire logic                     left_adjust_i,
  input  wire logic                     zero_pad_i,
  output logic [itd_pkg::CharW-1:0]     out_char_o,
  output logic                          last_o
);
  import itd_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   bcd_adj;
  logic              neg_q;
  logic [WidthW-1:0] width_q, width_sat;
  logic              ladj_q, zpad_q;
  logic [LenW-1:0]   len_q, len_d, ndig;
  logic [WidthW-1:0] pad_q, pad_d;
  logic [WidthW-1:0] last_pos_q, last_pos_d;
  logic [WidthW-1:0] pos_q;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q;
  logic              in_pad;
  logic [WidthW-1:0] tpos;
  logic [LenW-1:0]   didx;
  logic [3:0]        digit;

  assign width_sat = ({1'b0, field_width_i} > (WidthW+1)'(MaxFieldWidth)) ?
                     WidthW'(MaxFieldWidth) : field_width_i;

  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
    bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
    mag_d = {mag_q[ValueW-2:0], 1'b0};
  end

  always_comb begin
    ndig = LenW'(1);
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        ndig = LenW'(i + 1);
      end
    end
    len_d = ndig + LenW'(neg_q);
    if (WidthW'(len_d) < width_q) begin
      pad_d = width_q - WidthW'(len_d);
    end else begin
      pad_d = '0;
    end
    last_pos_d = WidthW'(len_d) + pad_d - WidthW'(1);
  end

  always_comb begin
    if (ladj_q) begin
      in_pad = (pos_q >= WidthW'(len_q));
      tpos   = pos_q;
    end else begin
      in_pad = (pos_q < pad_q);
      tpos   = pos_q - pad_q;
    end
    didx  = len_q - LenW'(1) - tpos[LenW-1:0];
    digit = 4'd0;
    for (int i = 0; i < NumDigits; i++) begin
      if (didx == LenW'(i)) begin
        digit = bcd_q[4*i +: 4];
      end
    end
    if (in_pad) begin
      char_d = zpad_q ? ChZero : ChSpace;
    end else if (neg_q && (tpos == '0)) begin
      char_d = ChMinus;
    end else begin
      char_d = ChZero + CharW'(digit);
    end
  end

  assign sts_o.last_char = (pos_q == last_pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load) begin
      pos_q <= '0;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q + WidthW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= value_i[ValueW-1];
      mag_q   <= value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      bcd_q   <= '0;
      width_q <= width_sat;
      ladj_q  <= left_adjust_i;
      zpad_q  <= zero_pad_i;
    end else if (cmd_i.shift) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.size) begin
      len_q      <= len_d;
      pad_q      <= pad_d;
      last_pos_q <= last_pos_d;
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= sts_o.last_char;
    end
  end

  assign out_char_o = char_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// File: rtl/int_to_decimal_padded_ascii_top.sv
// Signed decimal field formatter, printf %d style, one ASCII character out per cycle
// while the receiver is ready. The 32-step bit-serial BCD converter runs before the
// first character; a new field is accepted only after the last character of the
// previous field has been emitted.
// Reset: asynchronous, active low; clears the controller, output valid and the
// character position only. Depends on itd_pkg, itd_in_if, itd_out_if, itd_ctrl, itd_datapath.
`default_nettype none

module int_to_decimal_padded_ascii_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itd_in_if.sink    in_i,
  itd_out_if.source out_o
);
  import itd_pkg::*;

  itd_cmd_t cmd;
  itd_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  itd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (in_i.value),
    .field_width_i (in_i.field_width),
    .left_adjust_i (in_i.left_adjust),
    .zero_pad_i    (in_i.zero_pad),
    .out_char_o    (out_o.out_char),
    .last_o        (out_o.last)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

// File: bench/itd_checker.sv
`timescale 1ns / 1ps
// Checker for the decimal field formatter: watches both channels, predicts
// the ASCII text of each accepted request and compares it character by character.
// Depends on itd_pkg, itd_in_if and itd_out_if.

module itd_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itd_in_if           in_mon,
  itd_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import itd_pkg::*;

  localparam int unsigned Radix     = 10;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } field_char_t;

  field_char_t expected_chars[$];
  int unsigned fail_count = 0;

  function automatic void format_field(input logic signed [ValueW-1:0] value,
                                       input logic [WidthW-1:0] width,
                                       input logic ladj,
                                       input logic zpad);
    logic [ValueW-1:0] mag;
    logic [CharW-1:0]  text[12];
    logic [CharW-1:0]  pad_ch;
    int unsigned       len;
    int unsigned       pad;
    int unsigned       fw;
    field_char_t       field[$];
    mag    = value[ValueW-1] ? ValueW'(-value) : ValueW'(value);
    pad_ch = zpad ? ChZero : ChSpace;
    len    = 0;
    do begin
      text[len] = ChZero + CharW'(mag % Radix);
      mag       = mag / Radix;
      len++;
    end while (mag != 0);
    if (value[ValueW-1]) begin
      text[len] = ChMinus;
      len++;
    end
    fw  = (width > MaxFieldWidth) ? MaxFieldWidth : width;
    pad = (len < fw) ? fw - len : 0;
    if (!ladj) begin
      repeat (pad) field.push_back('{ch: pad_ch, last: 1'b0});
    end
    for (int i = len; i > 0; i--) begin
      field.push_back('{ch: text[i-1], last: 1'b0});
    end
    if (ladj) begin
      repeat (pad) field.push_back('{ch: pad_ch, last: 1'b0});
    end
    field[field.size()-1].last = 1'b1;
    foreach (field[i]) expected_chars.push_back(field[i]);
  endfunction

  always @(posedge clk_i) begin
    field_char_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        format_field(in_mon.value, in_mon.field_width, in_mon.left_adjust, in_mon.zero_pad);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReport) begin
            $display("%0t: unexpected char %0d last %0b", $realtime, out_mon.out_char,
                     out_mon.last);
          end
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== out_mon.out_char || want.last !== out_mon.last) begin
            fail_count++;
            if (fail_count <= MaxReport) begin
              $display("%0t: char mismatch: expected %0d last %0b, got %0d last %0b",
                       $realtime, want.ch, want.last, out_mon.out_char, out_mon.last);
            end
          end
        end
      end
      fail_count_o <= fail_count;
      pending_o    <= expected_chars.size();
    end
  end

endmodule

// File: bench/tb_int_to_decimal_padded_ascii_top.sv
`timescale 1ns / 1ps
// Testbench top for int_to_decimal_padded_ascii_top: drives format requests and
// output backpressure, gives the verdict. Depends on itd_pkg, the itd interfaces,
// the formatter RTL and itd_checker.

module tb_int_to_decimal_padded_ascii_top;
  import itd_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned ItemsPerPhase = 64;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainCycles  = 120;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned phase;
  int unsigned cycle_count;
  logic        rx_hold = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  itd_in_if  in_if ();
  itd_out_if out_if ();

  int_to_decimal_padded_ascii_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  itd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_int_to_decimal_padded_ascii_top NOT OK");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off while rx_hold is set
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hold off the receiver long enough to fill the block
  initial begin
    wait (phase == 2);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_field(input logic signed [ValueW-1:0] value,
                            input logic [WidthW-1:0] width,
                            input logic ladj,
                            input logic zpad);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.value       <= value;
    in_if.field_width <= width;
    in_if.left_adjust <= ladj;
    in_if.zero_pad    <= zpad;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random_field();
    logic signed [ValueW-1:0] v;
    logic [WidthW-1:0]        w;
    int unsigned              k;
    case ($urandom_range(5))
      0, 1: v = $urandom();
      2: v = $urandom_range(1999) - 999;
      3: begin
        k = $urandom_range(9);
        v = (10 ** k) - $urandom_range(1);
        if ($urandom_range(1)) v = -v;
      end
      4: v = $urandom_range(9);
      default: begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    w = ($urandom_range(3) == 0) ? WidthW'($urandom_range(63)) : WidthW'($urandom_range(15));
    send_field(v, w, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.value       <= '0;
    in_if.field_width <= '0;
    in_if.left_adjust <= 1'b0;
    in_if.zero_pad    <= 1'b0;
    phase       = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 74;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_field(0, 0, 1'b0, 1'b0);
    send_field(0, 63, 1'b1, 1'b1);
    send_field(32'sh8000_0000, 0, 1'b0, 1'b0);
    send_field(32'sh8000_0000, 20, 1'b0, 1'b1);
    send_field(32'sh8000_0000, 63, 1'b1, 1'b0);
    send_field(32'sh7fff_ffff, 63, 1'b1, 1'b1);
    send_field(32'sh7fff_ffff, 10, 1'b0, 1'b0);
    send_field(-1, 5, 1'b0, 1'b1);
    send_field(-5, 4, 1'b1, 1'b1);
    send_field(-5, 4, 1'b1, 1'b0);
    send_field(-10, 63, 1'b0, 1'b0);
    send_field(12345, 3, 1'b1, 1'b1);
    send_field(-12345, 2, 1'b0, 1'b1);
    send_field(1234567890, 10, 1'b0, 1'b1);
    send_field(-1234567890, 11, 1'b1, 1'b0);
    send_field(9, 1, 1'b0, 1'b0);
    send_field(10, 1, 1'b1, 1'b0);
    send_field(-999999999, 42, 1'b0, 1'b1);
    send_field(1000000000, 21, 1'b1, 1'b1);

    repeat (ItemsPerPhase) send_random_field();
    phase       = 1;
    tx_idle_pct = 74;
    rx_idle_pct = 31;
    repeat (ItemsPerPhase) send_random_field();
    phase       = 2;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (ItemsPerPhase) send_random_field();
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_int_to_decimal_padded_ascii_top OK");
    end else begin
      $display("tb_int_to_decimal_padded_ascii_top NOT OK");
    end
    $finish;
  end

endmodule
